// ===== rtl/tas_pkg.sv =====
// Shared types and constants for the topic assignment sampler.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package tas_pkg;

  // Table dimensions
  localparam int TOPICS     = 16;
  localparam int VOCAB_SIZE = 1024;
  localparam int DOC_COUNT  = 256;

  // Fixed field widths of the channels
  localparam int MODE_W   = 2;
  localparam int DOC_W    = 8;
  localparam int TIDX_W   = 4;
  localparam int WORD_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;

  // Derived sizes
  localparam int TOPIC_W     = $clog2(TOPICS);
  localparam int CNT_W       = $clog2(TOPICS + 1);
  localparam int THETA_DEPTH = DOC_COUNT * TOPICS;
  localparam int THETA_AW    = $clog2(THETA_DEPTH);
  localparam int PHI_DEPTH   = TOPICS * VOCAB_SIZE;
  localparam int PHI_AW      = $clog2(PHI_DEPTH);
  localparam int PROD_W      = 2 * WEIGHT_W;
  localparam int ACC_W       = PROD_W + TOPIC_W;
  localparam int THR_W       = ACC_W + FRAC_W;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_THETA  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PHI    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_SCALE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tas_in_if.sv =====
// Input channel of the topic assignment sampler: valid/ready plus item fields.
// Depends on tas_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tas_in_if;
  logic                         valid;
  logic                         ready;
  logic [tas_pkg::MODE_W-1:0]   mode;
  logic [tas_pkg::DOC_W-1:0]    doc_index;
  logic [tas_pkg::TIDX_W-1:0]   topic_index;
  logic [tas_pkg::WORD_W-1:0]   word_index;
  logic [tas_pkg::WEIGHT_W-1:0] weight_value;
  logic [tas_pkg::FRAC_W-1:0]   uniform_fraction;

  modport source (
    output valid, mode, doc_index, topic_index, word_index, weight_value,
           uniform_fraction,
    input  ready
  );

  modport sink (
    input  valid, mode, doc_index, topic_index, word_index, weight_value,
           uniform_fraction,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tas_out_if.sv =====
// Result channel of the topic assignment sampler: valid/ready plus result fields.
// Depends on tas_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tas_out_if;
  logic                       valid;
  logic                       ready;
  logic [tas_pkg::TIDX_W-1:0] sampled_topic;
  logic                       is_sample;

  modport source (
    output valid, sampled_topic, is_sample,
    input  ready
  );

  modport sink (
    input  valid, sampled_topic, is_sample,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/topic_assignment_sampler_top.sv =====
// Topic assignment sampler: weight tables, shared multiplier and scan sequencer.
// Depends on tas_pkg, tas_in_if and tas_out_if.
//
// Usage:
//   in_ch carries one item per beat. Mode 0 writes a document-topic weight,
//   mode 1 a topic-word weight, mode 2 samples a topic for (doc, word) from
//   the product weights by inverse CDF against uniform_fraction. Mode 3 is a
//   no-op. Every item yields exactly one beat on out_ch.
//   Writes (and mode 3) complete at the accepting edge; the acknowledge beat
//   is presented the next cycle.
//   A sample takes two passes of one weight product per cycle through the
//   table read ports and a single 16x16 multiplier: one pass to total the
//   weights, a scaling state, one pass comparing the running sum. in_ch
//   stays not ready from acceptance until the result has been loaded.
//   One result register sits on out_ch. While it holds an untaken beat, new
//   items are accepted only in the cycle the receiver takes it; a stalled
//   receiver holds the beat steady and blocks further input.
//   Reset clears the sequencer and the result register's valid flag. Table contents are
//   not cleared; read only entries that have been written.
`timescale 1ns / 1ps
`default_nettype none

module topic_assignment_sampler_top (
  input  wire logic  clk,
  input  wire logic  rst,
  tas_in_if.sink     in_ch,
  tas_out_if.source  out_ch
);

  // Weight tables
  logic [tas_pkg::WEIGHT_W-1:0] theta_mem [tas_pkg::THETA_DEPTH];
  logic [tas_pkg::WEIGHT_W-1:0] phi_mem   [tas_pkg::PHI_DEPTH];

  tas_pkg::state_t state;
  tas_pkg::state_t state_next;

  // Sequencer and datapath registers
  logic [tas_pkg::CNT_W-1:0]    cnt;
  logic [tas_pkg::DOC_W-1:0]    doc_reg;
  logic [tas_pkg::WORD_W-1:0]   word_reg;
  logic [tas_pkg::FRAC_W-1:0]   frac_reg;
  logic                         smp_ok;
  logic                         rd_vld;
  logic [tas_pkg::TOPIC_W-1:0]  rd_topic;
  logic [tas_pkg::WEIGHT_W-1:0] theta_q;
  logic [tas_pkg::WEIGHT_W-1:0] phi_q;
  logic                         mul_vld;
  logic [tas_pkg::TOPIC_W-1:0]  mul_topic;
  logic [tas_pkg::PROD_W-1:0]   prod;
  logic [tas_pkg::ACC_W-1:0]    acc;
  logic [tas_pkg::THR_W-1:0]    thr;
  logic                         found;
  logic [tas_pkg::TOPIC_W-1:0]  pick;
  logic                         out_valid;
  logic [tas_pkg::TIDX_W-1:0]   out_topic;
  logic                         out_is_sample;

  // Control from the sequencer
  logic                         in_ready;
  logic                         issue;
  logic                         pass_end;
  logic                         load_result;
  logic                         accept;
  logic                         accept_sample;
  logic                         out_free;
  logic [tas_pkg::TOPIC_W-1:0]  cnt_idx;
  logic [tas_pkg::ACC_W-1:0]    acc_sum;
  logic [tas_pkg::THETA_AW-1:0] theta_wr_addr;
  logic [tas_pkg::PHI_AW-1:0]   phi_wr_addr;
  logic [tas_pkg::THETA_AW-1:0] theta_rd_addr;
  logic [tas_pkg::PHI_AW-1:0]   phi_rd_addr;
  logic                         theta_we;
  logic                         phi_we;

  assign out_free      = !out_valid || out_ch.ready;
  assign accept        = in_ch.valid && in_ready;
  assign accept_sample = accept && (in_ch.mode == tas_pkg::MODE_SAMPLE);
  assign cnt_idx       = cnt[tas_pkg::TOPIC_W-1:0];
  assign acc_sum       = acc + tas_pkg::ACC_W'(prod);

  // Table addresses: row-major, doc*TOPICS+topic and topic*VOCAB_SIZE+word
  assign theta_wr_addr = tas_pkg::THETA_AW'(in_ch.doc_index) *
                         tas_pkg::THETA_AW'(tas_pkg::TOPICS) +
                         tas_pkg::THETA_AW'(in_ch.topic_index);
  assign phi_wr_addr   = tas_pkg::PHI_AW'(in_ch.topic_index) *
                         tas_pkg::PHI_AW'(tas_pkg::VOCAB_SIZE) +
                         tas_pkg::PHI_AW'(in_ch.word_index);
  assign theta_rd_addr = tas_pkg::THETA_AW'(doc_reg) *
                         tas_pkg::THETA_AW'(tas_pkg::TOPICS) +
                         tas_pkg::THETA_AW'(cnt_idx);
  assign phi_rd_addr   = tas_pkg::PHI_AW'(cnt_idx) *
                         tas_pkg::PHI_AW'(tas_pkg::VOCAB_SIZE) +
                         tas_pkg::PHI_AW'(word_reg);

  // Drop writes whose indexes fall outside the tables
  assign theta_we = accept && (in_ch.mode == tas_pkg::MODE_THETA) &&
                    (32'(in_ch.doc_index) < tas_pkg::DOC_COUNT) &&
                    (32'(in_ch.topic_index) < tas_pkg::TOPICS);
  assign phi_we   = accept && (in_ch.mode == tas_pkg::MODE_PHI) &&
                    (32'(in_ch.topic_index) < tas_pkg::TOPICS) &&
                    (32'(in_ch.word_index) < tas_pkg::VOCAB_SIZE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tas_pkg::ST_IDLE: begin
        if (accept_sample) state_next = tas_pkg::ST_TOTAL;
      end
      tas_pkg::ST_TOTAL: begin
        if (pass_end) state_next = tas_pkg::ST_SCALE;
      end
      tas_pkg::ST_SCALE: begin
        state_next = tas_pkg::ST_SCAN;
      end
      tas_pkg::ST_SCAN: begin
        if (pass_end) state_next = tas_pkg::ST_DONE;
      end
      tas_pkg::ST_DONE: begin
        if (out_free) state_next = tas_pkg::ST_IDLE;
      end
      default: state_next = tas_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs; hold input off while in reset
  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    pass_end    = 1'b0;
    load_result = 1'b0;
    case (state)
      tas_pkg::ST_IDLE: begin
        in_ready = out_free && !rst;
      end
      tas_pkg::ST_TOTAL, tas_pkg::ST_SCAN: begin
        issue    = (32'(cnt) < tas_pkg::TOPICS);
        pass_end = (32'(cnt) == tas_pkg::TOPICS) && !rd_vld && !mul_vld;
      end
      tas_pkg::ST_DONE: begin
        load_result = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // Table write and registered read ports
  always_ff @(posedge clk) begin
    if (theta_we) theta_mem[theta_wr_addr] <= in_ch.weight_value;
    theta_q <= theta_mem[theta_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (phi_we) phi_mem[phi_wr_addr] <= in_ch.weight_value;
    phi_q <= phi_mem[phi_rd_addr];
  end

  // Capture sample operands
  always_ff @(posedge clk) begin
    if (accept_sample) begin
      doc_reg  <= in_ch.doc_index;
      word_reg <= in_ch.word_index;
      frac_reg <= in_ch.uniform_fraction;
      smp_ok   <= (32'(in_ch.doc_index) < tas_pkg::DOC_COUNT) &&
                  (32'(in_ch.word_index) < tas_pkg::VOCAB_SIZE);
    end
  end

  // Shared multiplier; out-of-range samples see zero weights
  always_ff @(posedge clk) begin
    prod      <= smp_ok ? tas_pkg::PROD_W'(theta_q) * tas_pkg::PROD_W'(phi_q)
                        : '0;
    mul_topic <= rd_topic;
    rd_topic  <= cnt_idx;
  end

  // Scaled threshold u*T, computed once between the passes
  always_ff @(posedge clk) begin
    if (state == tas_pkg::ST_SCALE) thr <= tas_pkg::THR_W'(frac_reg) * tas_pkg::THR_W'(acc);
  end

  // Topic counter, pipeline valids, accumulator and first-hit search
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tas_pkg::ST_IDLE;
      cnt     <= '0;
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
      acc     <= '0;
      found   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= issue;
      mul_vld <= rd_vld;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end else if (pass_end || accept_sample) begin
        cnt <= '0;
      end
      if (accept_sample || state == tas_pkg::ST_SCALE) begin
        acc   <= '0;
        found <= 1'b0;
      end else if (mul_vld) begin
        acc <= acc_sum;
        if (state == tas_pkg::ST_SCAN && !found &&
            ({acc_sum, {tas_pkg::FRAC_W{1'b0}}} > thr)) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Hold the first qualifying topic
  always_ff @(posedge clk) begin
    if (state == tas_pkg::ST_SCAN && mul_vld && !found &&
        ({acc_sum, {tas_pkg::FRAC_W{1'b0}}} > thr)) begin
      pick <= mul_topic;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !accept_sample) begin
      out_valid <= 1'b1;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !accept_sample) begin
      out_topic     <= '0;
      out_is_sample <= 1'b0;
    end else if (load_result) begin
      out_topic     <= found ? tas_pkg::TIDX_W'(pick)
                             : tas_pkg::TIDX_W'(tas_pkg::TOPICS - 1);
      out_is_sample <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.sampled_topic = out_topic;
  assign out_ch.is_sample     = out_is_sample;

  // Checks on the sequencer and datapath
  a_sample_starts_total: assert property (@(posedge clk) disable iff (rst)
    accept_sample |=> state == tas_pkg::ST_TOTAL)
    else $error("accepted sample did not start the total pass");

  a_pipe_follows: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> mul_vld)
    else $error("read beat did not reach the multiplier");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == tas_pkg::ST_IDLE |-> !rd_vld && !mul_vld)
    else $error("pipeline busy while idle");

  a_ack_topic_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_is_sample |-> out_topic == '0)
    else $error("write acknowledge carries a topic");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    state == tas_pkg::ST_SCAN && found |=> found)
    else $error("first-hit flag dropped during the scan");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for topic_assignment_sampler_top: weight-table writes and
// inverse-CDF topic samples, checked beat by beat against a local predictor.
// Depends on tas_pkg, tas_in_if, tas_out_if and the sampler RTL.

module testbench;
  import tas_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int DIR_ROWS     = 24;
  localparam int DRAIN_EVERY  = 200;
  localparam int TAIL_CYCLES  = 64;
  localparam int POOL         = 8;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [DOC_W-1:0]    doc;
    logic [TIDX_W-1:0]   topic;
    logic [WORD_W-1:0]   word;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   frac;
  } token_t;

  typedef struct packed {
    token_t            tok;
    logic              fill;       // repeat the write over every topic
    logic              typed;      // expected topic given in the row
    logic [TIDX_W-1:0] topic_exp;
  } dir_row_t;

  typedef struct packed {
    logic [TIDX_W-1:0] topic;
    logic              is_sample;
  } topic_result_t;

  // Rows and columns that random samples draw from; together they toggle every index bit
  localparam logic [DOC_W-1:0] DOC_POOL [POOL] =
    '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33, 8'hCC};
  localparam logic [WORD_W-1:0] WORD_POOL [POOL] =
    '{10'h000, 10'h3FF, 10'h2AA, 10'h155, 10'h01F, 10'h3E0, 10'h0F0, 10'h30F};

  logic clk;
  logic rst;
  bit   idle_en;
  int   mismatch_count;
  int   items_sent;
  int   stall_left;

  // Predictor copy of the weight tables and which entries hold a written value
  logic [WEIGHT_W-1:0] theta_tbl [DOC_COUNT][TOPICS];
  logic [WEIGHT_W-1:0] phi_tbl   [TOPICS][VOCAB_SIZE];
  logic [TOPICS-1:0]   theta_seen [DOC_COUNT];
  logic [TOPICS-1:0]   phi_seen   [VOCAB_SIZE];

  topic_result_t pending_topics [$];
  dir_row_t      dir_rows [DIR_ROWS];

  tas_in_if  in_ch ();
  tas_out_if out_ch ();

  topic_assignment_sampler_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Inverse-CDF draw over the products theta*phi, compared against frac scaled by the total
  function automatic logic [TIDX_W-1:0] draw_topic(input logic [DOC_W-1:0] doc,
                                                   input logic [WORD_W-1:0] word,
                                                   input logic [FRAC_W-1:0] frac);
    logic [2*WEIGHT_W-1:0] prod [TOPICS];
    logic [63:0]           total;
    logic [63:0]           running;
    total   = '0;
    running = '0;
    for (int k = 0; k < TOPICS; k++) begin
      prod[k] = theta_tbl[doc][k] * phi_tbl[k][word];
      total += 64'(prod[k]);
    end
    for (int k = 0; k < TOPICS; k++) begin
      running += 64'(prod[k]);
      if ((running << 16) > 64'(frac) * total) return TIDX_W'(k);
    end
    return TIDX_W'(TOPICS - 1);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 40) return WEIGHT_W'($urandom_range(1, 15));
    if (r < 50) return WEIGHT_W'(1) << $urandom_range(0, WEIGHT_W - 1);
    return WEIGHT_W'($urandom);
  endfunction

  function automatic logic [FRAC_W-1:0] pick_frac();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return FRAC_W'($urandom_range(16'h7FF0, 16'h8010));
    return FRAC_W'($urandom);
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic token_t rand_token();
    logic [63:0] raw;
    token_t      t;
    raw = {$urandom, $urandom};
    t   = raw[$bits(token_t)-1:0];
    return t;
  endfunction

  // Present one beat, hold it until taken, then update tables and queue its result
  task automatic send_token(input token_t t, input logic typed,
                            input logic [TIDX_W-1:0] topic_exp);
    int            gap;
    topic_result_t want;
    gap = (idle_en && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= t.mode;
    in_ch.doc_index        <= t.doc;
    in_ch.topic_index      <= t.topic;
    in_ch.word_index       <= t.word;
    in_ch.weight_value     <= t.weight;
    in_ch.uniform_fraction <= t.frac;
    do @(posedge clk); while (!in_ch.ready);

    want.topic     = '0;
    want.is_sample = (t.mode == MODE_SAMPLE);
    case (t.mode)
      MODE_THETA: begin
        theta_tbl[t.doc][t.topic]  = t.weight;
        theta_seen[t.doc][t.topic] = 1'b1;
      end
      MODE_PHI: begin
        phi_tbl[t.topic][t.word]  = t.weight;
        phi_seen[t.word][t.topic] = 1'b1;
      end
      MODE_SAMPLE: want.topic = draw_topic(t.doc, t.word, t.frac);
      default: ;
    endcase
    if (typed) want.topic = topic_exp;
    pending_topics = {pending_topics, want};
    items_sent++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_topics.size() != 0);
  endtask

  // Write all topics of one pool row (theta) or column (phi)
  task automatic fill_burst(input logic to_phi);
    token_t              t;
    int                  style;
    logic [WEIGHT_W-1:0] level;
    t      = rand_token();
    t.mode = to_phi ? MODE_PHI : MODE_THETA;
    t.doc  = DOC_POOL[$urandom_range(0, POOL - 1)];
    t.word = WORD_POOL[$urandom_range(0, POOL - 1)];
    style  = $urandom_range(0, 9);
    level  = (style < 2) ? '0 : pick_weight();
    for (int k = 0; k < TOPICS; k++) begin
      t.topic  = TIDX_W'(k);
      t.weight = (style < 4) ? level : pick_weight();
      send_token(t, 1'b0, '0);
    end
  endtask

  // Take result beats, compare against the oldest expectation, drive receiver stalls
  always @(posedge clk) begin
    topic_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_topics.size() == 0) begin
          $display("%0t: result beat with nothing expected: topic %0d is_sample %0b",
                   $time, out_ch.sampled_topic, out_ch.is_sample);
          mismatch_count++;
        end else begin
          want = pending_topics.pop_front();
          if (out_ch.sampled_topic !== want.topic) begin
            $display("%0t: sampled_topic expected %0d actual %0d",
                     $time, want.topic, out_ch.sampled_topic);
            mismatch_count++;
          end
          if (out_ch.is_sample !== want.is_sample) begin
            $display("%0t: is_sample expected %0b actual %0b",
                     $time, want.is_sample, out_ch.is_sample);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    token_t           t;
    int               r;
    int               random_base;
    int               next_drain;
    logic [DOC_W-1:0]  docs_ok [$];
    logic [WORD_W-1:0] words_ok [$];

    mismatch_count = 0;
    items_sent     = 0;
    idle_en        = 1'b1;
    for (int d = 0; d < DOC_COUNT; d++) theta_seen[d] = '0;
    for (int w = 0; w < VOCAB_SIZE; w++) phi_seen[w] = '0;

    rst                    <= 1'b1;
    in_ch.valid            <= 1'b0;
    in_ch.mode             <= MODE_THETA;
    in_ch.doc_index        <= '0;
    in_ch.topic_index      <= '0;
    in_ch.word_index       <= '0;
    in_ch.weight_value     <= '0;
    in_ch.uniform_fraction <= '0;

    // Directed rows: fill, then typed ack/zero-total/single-topic cases, rest predicted
    dir_rows = '{
      '{'{MODE_THETA,  8'h00, 4'h0, 10'h000, 16'h0000, 16'h0000}, 1'b1, 1'b1, 4'd0},
      '{'{MODE_PHI,    8'h00, 4'h0, 10'h000, 16'h0000, 16'h0000}, 1'b1, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'h00, 4'hF, 10'h000, 16'hABCD, 16'h0000}, 1'b0, 1'b1, 4'd15},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h000, 16'h0000, 16'hFFFF}, 1'b0, 1'b1, 4'd15},
      '{'{MODE_THETA,  8'h00, 4'h5, 10'h000, 16'hFFFF, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_PHI,    8'h00, 4'h5, 10'h000, 16'hFFFF, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h000, 16'h0000, 16'h0000}, 1'b0, 1'b1, 4'd5},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h000, 16'h0000, 16'hFFFF}, 1'b0, 1'b1, 4'd5},
      '{'{MODE_THETA,  8'h00, 4'hF, 10'h000, 16'hFFFF, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_PHI,    8'h00, 4'hF, 10'h000, 16'hFFFF, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h000, 16'h0000, 16'h8000}, 1'b0, 1'b0, 4'd0},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h000, 16'h0000, 16'h7FFF}, 1'b0, 1'b0, 4'd0},
      '{'{MODE_THETA,  8'hFF, 4'h0, 10'h000, 16'hFFFF, 16'h0000}, 1'b1, 1'b1, 4'd0},
      '{'{MODE_PHI,    8'h00, 4'h0, 10'h3FF, 16'h0001, 16'h0000}, 1'b1, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'hFF, 4'h0, 10'h3FF, 16'h0000, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'hFF, 4'h0, 10'h3FF, 16'h0000, 16'hFFFF}, 1'b0, 1'b0, 4'd0},
      '{'{MODE_PHI,    8'h00, 4'h0, 10'h000, 16'h1234, 16'h0000}, 1'b1, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h000, 16'h0000, 16'h4000}, 1'b0, 1'b0, 4'd0},
      '{'{MODE_NOP,    8'hFF, 4'hF, 10'h3FF, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_THETA,  8'hFF, 4'h0, 10'h000, 16'h0000, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'hFF, 4'h0, 10'h3FF, 16'h0000, 16'h0001}, 1'b0, 1'b0, 4'd0},
      '{'{MODE_SAMPLE, 8'h00, 4'h0, 10'h3FF, 16'h0000, 16'hC000}, 1'b0, 1'b0, 4'd0},
      '{'{MODE_PHI,    8'h00, 4'hF, 10'h3FF, 16'hFFFF, 16'h0000}, 1'b0, 1'b1, 4'd0},
      '{'{MODE_SAMPLE, 8'hFF, 4'h0, 10'h000, 16'h0000, 16'h0000}, 1'b0, 1'b0, 4'd0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fill) begin
        for (int k = 0; k < TOPICS; k++) begin
          t       = dir_rows[i].tok;
          t.topic = TIDX_W'(k);
          send_token(t, dir_rows[i].typed, dir_rows[i].topic_exp);
        end
      end else begin
        send_token(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].topic_exp);
      end
    end
    drain_results();

    // Random part: samples over fully written pool rows and columns, mixed with writes and no-ops
    random_base = items_sent;
    next_drain  = DRAIN_EVERY;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      if (items_sent - random_base >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
        idle_en = ($urandom_range(0, 3) != 0);
      end
      t = rand_token();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        docs_ok.delete();
        words_ok.delete();
        for (int p = 0; p < POOL; p++) begin
          if (&theta_seen[DOC_POOL[p]]) docs_ok = {docs_ok, DOC_POOL[p]};
          if (&phi_seen[WORD_POOL[p]]) words_ok = {words_ok, WORD_POOL[p]};
        end
        if (docs_ok.size() == 0) begin
          fill_burst(1'b0);
        end else if (words_ok.size() == 0) begin
          fill_burst(1'b1);
        end else begin
          t.mode = MODE_SAMPLE;
          t.doc  = docs_ok[$urandom_range(0, docs_ok.size() - 1)];
          t.word = words_ok[$urandom_range(0, words_ok.size() - 1)];
          t.frac = pick_frac();
          send_token(t, 1'b0, '0);
        end
      end else if (r < 85) begin
        // Single write, mostly into the pools, sometimes anywhere
        t.mode   = $urandom_range(0, 1) ? MODE_PHI : MODE_THETA;
        t.weight = pick_weight();
        if ($urandom_range(0, 4) != 0) begin
          t.doc  = DOC_POOL[$urandom_range(0, POOL - 1)];
          t.word = WORD_POOL[$urandom_range(0, POOL - 1)];
        end
        send_token(t, 1'b0, '0);
      end else if (r < 93) begin
        fill_burst(1'($urandom_range(0, 1)));
      end else begin
        t.mode = MODE_NOP;
        send_token(t, 1'b0, '0);
      end
    end

    // Let the last results come back, then allow for stray beats
    in_ch.valid <= 1'b0;
    while (pending_topics.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tas_pkg.sv
rtl/tas_in_if.sv
rtl/tas_out_if.sv
rtl/topic_assignment_sampler_top.sv
tb/testbench.sv
